>>> design/bacf_pkg.sv
// Shared types, constants and configuration codes for the bracket-aware character finder.
package bacf_pkg;

    // Sizing of the closer stack and the position counter
    localparam int unsigned STACK_DEPTH = 64;
    localparam longint unsigned MAX_LENGTH = 64'd65536;
    localparam int unsigned STACK_ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam longint unsigned POS_LIMIT =
        ((MAX_LENGTH - 64'd1) > 64'd65535) ? 64'd65535 : (MAX_LENGTH - 64'd1);
    localparam logic [15:0] POS_CAP = POS_LIMIT[15:0];

    // Special characters
    localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
    localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;
    localparam logic [7:0] CH_BACKSLASH   = 8'h5C;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TARGET_A     = 2'd0,
        CFG_TARGET_B     = 2'd1,
        CFG_TARGET_C     = 2'd2,
        CFG_TARGET_COUNT = 2'd3
    } cfg_idx_t;

    // Input request payload
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } item_t;

    // Result payload
    typedef struct packed {
        logic        found;
        logic [15:0] position;
        logic        length_overflow;
        logic        nesting_overflow;
    } result_t;

    // Classified byte handed from the front end to the back end
    typedef struct packed {
        logic is_target;
        logic is_open;
        logic is_close;
        logic brace;
        logic is_bslash;
        logic last;
    } cls_t;

endpackage

>>> design/bracket_aware_char_finder.sv
// Top level of the bracket-aware character finder.
// Scans one string byte per request and returns one result per string: the first
// unescaped target byte found outside all brackets, or a not-found result after the
// byte marked last. The block sustains one byte per clock cycle while no result is
// stalled: the back end updates escape, position and nesting state per byte, keeping
// the top of the closer stack in a register while the stack memory's read port
// pre-reads the entry below it. A two-entry queue separates byte classification from
// state update, and a result register separates the back end from the result
// consumer. With nothing waiting ahead of it, a byte is registered in a queue slot and
// its result in the result register before the result is valid. The input stalls only
// while the queue is full, which happens only while a stalled result waits. The stack
// memory needs no clearing pass. Write configuration only while no string is in flight.
module bracket_aware_char_finder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  bacf_pkg::cfg_idx_t cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  bacf_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output bacf_pkg::result_t  result
);
    import bacf_pkg::*;

    cls_t cls;
    cls_t head;
    logic head_valid;
    logic pop;
    logic full;

    bacf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cls       (cls)
    );

    bacf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (item_valid),
        .push_data  (cls),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    assign item_stall = full;

    bacf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> design/bacf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bacf_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/bacf_front.sv
// Front end: configuration registers and byte classification.
module bacf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  bacf_pkg::cfg_idx_t cfg_index,
    input  logic [7:0]        cfg_data,
    input  bacf_pkg::item_t   item,
    output bacf_pkg::cls_t    cls
);
    import bacf_pkg::*;

    logic [7:0] target_a_reg;
    logic [7:0] target_b_reg;
    logic [7:0] target_c_reg;
    logic [1:0] target_count_reg;
    logic       use_b;
    logic       use_c;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_a_reg     <= 8'd0;
            target_b_reg     <= 8'd0;
            target_c_reg     <= 8'd0;
            target_count_reg <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_A:     target_a_reg     <= cfg_data;
                CFG_TARGET_B:     target_b_reg     <= cfg_data;
                CFG_TARGET_C:     target_c_reg     <= cfg_data;
                CFG_TARGET_COUNT: target_count_reg <= cfg_data[1:0];
            endcase
        end
    end

    // Count of zero acts as one; two and three enable target b
    assign use_b = target_count_reg[1];
    assign use_c = (target_count_reg == 2'd3);

    // Classify the incoming byte
    always_comb
    begin
        cls.is_target = (item.byte_in == target_a_reg)
                      || (use_b && (item.byte_in == target_b_reg))
                      || (use_c && (item.byte_in == target_c_reg));
        cls.is_open   = (item.byte_in == CH_OPEN_PAREN) || (item.byte_in == CH_OPEN_BRACE);
        cls.is_close  = (item.byte_in == CH_CLOSE_PAREN) || (item.byte_in == CH_CLOSE_BRACE);
        cls.brace     = (item.byte_in == CH_OPEN_BRACE) || (item.byte_in == CH_CLOSE_BRACE);
        cls.is_bslash = (item.byte_in == CH_BACKSLASH);
        cls.last      = item.last;
    end

endmodule

>>> design/bacf_queue.sv
// Two-entry queue of classified bytes between front end and back end.
module bacf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bacf_pkg::cls_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output bacf_pkg::cls_t head
);
    import bacf_pkg::*;

    cls_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/bacf_back.sv
// Back end: escape, nesting and position tracking with the closer stack and result register.
module bacf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  bacf_pkg::cls_t   head,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output bacf_pkg::result_t result
);
    import bacf_pkg::*;

    logic [DEPTH_W-1:0]      depth_reg;
    logic [DEPTH_W-1:0]      depth_next;
    logic                    esc_reg;
    logic                    esc_next;
    logic [15:0]             idx_reg;
    logic [15:0]             idx_next;
    logic                    hit_reg;
    logic                    hit_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic                    drop_reg;
    logic                    drop_next;
    logic                    top_reg;
    logic                    top_next;
    logic                    byp_hit_reg;
    logic                    byp_data_reg;
    logic                    ram_rdata;
    logic                    below;
    logic                    ram_we;
    logic [STACK_ADDR_W-1:0] ram_waddr;
    logic [STACK_ADDR_W-1:0] ram_raddr;
    logic [DEPTH_W-1:0]      depth_m1;
    logic [DEPTH_W-1:0]      depth_next_m2;
    logic                    can_load;
    logic                    take;
    logic                    emit;
    result_t                 res_next;
    logic                    result_valid_reg;
    result_t                 result_reg;

    // Take a request when the result register is free or drains this cycle
    assign can_load = !result_valid_reg || !result_stall;
    assign take     = head_valid && can_load;
    assign pop      = take;

    // Entry just below the cached top, with write forwarding
    assign below    = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign depth_m1 = depth_reg - DEPTH_W'(1);

    // Process one classified byte
    always_comb
    begin
        depth_next = depth_reg;
        esc_next   = esc_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        sat_next   = sat_reg;
        drop_next  = drop_reg;
        top_next   = top_reg;
        ram_we     = 1'b0;
        ram_waddr  = depth_m1[STACK_ADDR_W-1:0];
        emit       = 1'b0;
        res_next   = '0;
        if (take)
        begin
            if (!hit_reg)
            begin
                if (head.is_target && (depth_reg == '0) && !esc_reg)
                begin
                    hit_next                  = 1'b1;
                    emit                      = 1'b1;
                    res_next.found            = 1'b1;
                    res_next.position         = idx_reg;
                    res_next.length_overflow  = sat_reg;
                    res_next.nesting_overflow = drop_reg;
                end
                else
                begin
                    if (head.is_open)
                    begin
                        if (depth_reg < DEPTH_W'(STACK_DEPTH))
                        begin
                            // Spill the old top into the memory, cache the new closer
                            ram_we     = (depth_reg != '0);
                            top_next   = head.brace;
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else if (head.is_close)
                    begin
                        if ((depth_reg != '0) && (top_reg == head.brace))
                        begin
                            top_next   = below;
                            depth_next = depth_m1;
                        end
                    end
                    esc_next = head.is_bslash && !esc_reg;
                    if (idx_reg >= POS_CAP)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 16'd1;
                    end
                    if (head.last)
                    begin
                        emit                      = 1'b1;
                        res_next.length_overflow  = sat_reg;
                        res_next.nesting_overflow = drop_next;
                    end
                end
            end
            if (head.last)
            begin
                depth_next = '0;
                esc_next   = 1'b0;
                idx_next   = 16'd0;
                hit_next   = 1'b0;
                sat_next   = 1'b0;
                drop_next  = 1'b0;
            end
        end
    end

    // Pre-read the entry that sits below the next top
    assign depth_next_m2 = depth_next - DEPTH_W'(2);
    assign ram_raddr     = depth_next_m2[STACK_ADDR_W-1:0];

    bacf_ram #(
        .WIDTH (1),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Hold per-string state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= '0;
            esc_reg          <= 1'b0;
            idx_reg          <= 16'd0;
            hit_reg          <= 1'b0;
            sat_reg          <= 1'b0;
            drop_reg         <= 1'b0;
            byp_hit_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg   <= depth_next;
            esc_reg     <= esc_next;
            idx_reg     <= idx_next;
            hit_reg     <= hit_next;
            sat_reg     <= sat_next;
            drop_reg    <= drop_next;
            byp_hit_reg <= ram_we && (ram_waddr == ram_raddr);
            if (can_load)
            begin
                result_valid_reg <= emit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        byp_data_reg <= top_reg;
        if (can_load && emit)
        begin
            result_reg <= res_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> design/bacf_checker.sv
// Port-level assertions for the bracket-aware character finder, bound to the top level.
module bacf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input bacf_pkg::result_t  result
);
    import bacf_pkg::*;

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

    // A not-found result carries position zero
    a_notfound_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.found) |-> (result.position == 16'd0))
        else $error("not-found result with nonzero position");

    // A hit past the position range sits at the saturated position
    a_sat_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.found && result.length_overflow) |->
            (result.position == POS_CAP))
        else $error("overflowed hit not at saturated position");

    // The input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result waiting");

endmodule

bind bracket_aware_char_finder bacf_checker u_bacf_checker (.*);
